// File: rtl/core/msp_pkg.sv
// shared types and constants of the memory pattern scanner
package msp_pkg;

	localparam int LEN_W = 5;

	localparam logic MEM_RW = 1'b0;
	localparam logic MEM_RO = 1'b1;

	typedef enum logic [1:0] {
		CFG_PATTERN_LOW    = 2'd0,
		CFG_PATTERN_HIGH   = 2'd1,
		CFG_PATTERN_LENGTH = 2'd2,
		CFG_MATCH_LIMIT    = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic [31:0] byte_address;
		logic        byte_writable;
		logic        restart;
	} scan_item_t;

	typedef struct packed {
		logic [31:0] match_address;
		logic        match_mode;
		logic [31:0] match_index;
		logic        stored;
	} hit_item_t;

	typedef struct packed {
		logic [63:0]      pattern_low;
		logic [63:0]      pattern_high;
		logic [LEN_W-1:0] pattern_length;
		logic [15:0]      match_limit;
	} cfg_t;

	typedef struct packed {
		logic      hit;
		hit_item_t item;
	} result_t;

endpackage

// File: rtl/core/msp_in_stage.sv
// input register stage holding one scan request
module msp_in_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               scan_valid,
	input  msp_pkg::scan_item_t scan_item,
	input  logic               advance,
	output logic               scan_stall,
	output logic               valid_s1,
	output msp_pkg::scan_item_t item_s1
);
	import msp_pkg::*;

	logic take;

	assign scan_stall = valid_s1 && !advance;
	assign take       = scan_valid && !scan_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= scan_item;
		end
	end

endmodule

// File: rtl/core/msp_match.sv
// window state, parallel pattern compare and match bookkeeping
module msp_match #(
	parameter int PATTERN_MAX = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            go,
	input  msp_pkg::scan_item_t item,
	input  msp_pkg::cfg_t   cfg,
	output msp_pkg::result_t res
);
	import msp_pkg::*;

	localparam int FW = $clog2(PATTERN_MAX + 1);
	localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

	logic [7:0]       win_byte_q [PATTERN_MAX];
	logic             win_wr_q   [PATTERN_MAX];
	logic [FW-1:0]    fill_q;
	logic [31:0]      next_addr_q;
	logic [31:0]      count_q;

	logic [7:0]       nb  [PATTERN_MAX];
	logic             nwr [PATTERN_MAX];
	logic             brk;
	logic [FW-1:0]    fill_new;
	logic [LEN_W-1:0] len;
	logic [LEN_W-1:0] first;
	logic [LEN_W-1:0] pos;
	logic [127:0]     pat;
	logic             eq;
	logic             hit;
	logic [31:0]      count_cur;

	always_comb begin
		// window breaks on restart or an address gap
		brk = item.restart || (fill_q != '0 && item.byte_address != next_addr_q);

		for (int j = 0; j < PATTERN_MAX; j++) begin
			if (j == PATTERN_MAX - 1) begin
				nb[j]  = item.data_byte;
				nwr[j] = item.byte_writable;
			end else begin
				nb[j]  = win_byte_q[j+1];
				nwr[j] = win_wr_q[j+1];
			end
		end

		if (brk) begin
			fill_new = FW'(1);
		end else if (fill_q == FW'(PATTERN_MAX)) begin
			fill_new = fill_q;
		end else begin
			fill_new = fill_q + FW'(1);
		end

		if (cfg.pattern_length == '0) begin
			len = LEN_W'(1);
		end else if (cfg.pattern_length > LEN_W'(PATTERN_MAX)) begin
			len = LEN_W'(PATTERN_MAX);
		end else begin
			len = cfg.pattern_length;
		end

		pat   = {cfg.pattern_high, cfg.pattern_low};
		first = LEN_W'(PATTERN_MAX) - len;
		eq    = 1'b1;
		pos   = '0;
		for (int i = 0; i < PATTERN_MAX; i++) begin
			pos = first + LEN_W'(i);
			if (LEN_W'(i) < len && nb[pos[IW-1:0]] != pat[8*i +: 8]) begin
				eq = 1'b0;
			end
		end

		hit       = (LEN_W'(fill_new) >= len) && eq;
		count_cur = item.restart ? 32'd0 : count_q;

		res.hit                = hit;
		res.item.match_address = item.byte_address - 32'(len) + 32'd1;
		res.item.match_mode    = nwr[first[IW-1:0]] ? MEM_RW : MEM_RO;
		res.item.match_index   = count_cur;
		res.item.stored        = count_cur < 32'(cfg.match_limit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			next_addr_q <= '0;
			count_q     <= '0;
		end else if (go) begin
			next_addr_q <= item.byte_address + 32'd1;
			fill_q      <= hit ? '0 : fill_new;
			if (hit && count_cur != 32'hFFFF_FFFF) begin
				count_q <= count_cur + 32'd1;
			end else begin
				count_q <= count_cur;
			end
		end
	end

	// window contents only count below the fill level, so no reset is needed
	always_ff @(posedge clk) begin
		if (go) begin
			for (int j = 0; j < PATTERN_MAX; j++) begin
				win_byte_q[j] <= nb[j];
				win_wr_q[j]   <= nwr[j];
			end
		end
	end

endmodule

// File: rtl/core/msp_out_stage.sv
// result register toward the match receiver
module msp_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  msp_pkg::result_t   res,
	input  logic               hit_stall,
	output logic               advance,
	output logic               hit_valid,
	output msp_pkg::hit_item_t hit_item
);
	import msp_pkg::*;

	assign advance = !hit_valid || !hit_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_valid <= 1'b0;
		end else if (advance) begin
			hit_valid <= go && res.hit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && go && res.hit) begin
			hit_item <= res.item;
		end
	end

endmodule

// File: rtl/core/memory_pattern_scanner.sv
// top level of the memory pattern scanner
// usage:
// - scan channel (scan_valid / scan_stall / scan_item) takes one memory byte per
//   request with its address, writable flag and restart flag
// - hit channel (hit_valid / hit_stall / hit_item) returns one request per
//   pattern occurrence: start address, access mode, match index, stored flag
// - cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes pattern
//   bytes, pattern length and match limit; cfg_ready is always high, writes
//   belong to idle periods only
// - a byte in the input register shows its match once the result register takes it
// - throughput: one byte per cycle unless stalled; the whole window compare runs in the
//   single logic stage between the input register and the result register
// - a receiver stall holds a pending result in the result register; the input register still
//   takes a byte while the result register waits, then scan_stall rises
// - reset clears window fill, expected address, match count and both valid
//   flags; pattern is all zero, length 1, limit 20 after reset
// - consecutive matches never overlap: the window empties after every hit
module memory_pattern_scanner #(
	parameter int PATTERN_MAX = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 scan_valid,
	output logic                 scan_stall,
	input  msp_pkg::scan_item_t  scan_item,
	output logic                 hit_valid,
	input  logic                 hit_stall,
	output msp_pkg::hit_item_t   hit_item,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [63:0]          cfg_data
);
	import msp_pkg::*;

	cfg_t       cfg_q;
	logic       valid_s1;
	scan_item_t item_s1;
	logic       advance;
	logic       go;
	result_t    res;

	// configuration registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern_low    <= '0;
			cfg_q.pattern_high   <= '0;
			cfg_q.pattern_length <= LEN_W'(1);
			cfg_q.match_limit    <= 16'd20;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_PATTERN_LOW: begin
					cfg_q.pattern_low <= cfg_data;
				end
				CFG_PATTERN_HIGH: begin
					cfg_q.pattern_high <= cfg_data;
				end
				CFG_PATTERN_LENGTH: begin
					cfg_q.pattern_length <= cfg_data[LEN_W-1:0];
				end
				CFG_MATCH_LIMIT: begin
					cfg_q.match_limit <= cfg_data[15:0];
				end
			endcase
		end
	end

	// input register
	msp_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.scan_valid (scan_valid),
		.scan_item  (scan_item),
		.advance    (advance),
		.scan_stall (scan_stall),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	// the held byte is consumed whenever the result register can move
	assign go = valid_s1 && advance;

	// window and compare
	msp_match #(
		.PATTERN_MAX (PATTERN_MAX)
	) u_match (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	// result register
	msp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.res       (res),
		.hit_stall (hit_stall),
		.advance   (advance),
		.hit_valid (hit_valid),
		.hit_item  (hit_item)
	);

`ifndef SYNTHESIS
	// upstream is held back only while a byte sits in the input register
	a_stall_needs_held: assert property (@(posedge clk) disable iff (!arst_n)
		scan_stall |-> valid_s1)
		else $error("scan_stall without a held byte");

	// a blocked result with a held byte must back-pressure the scan side
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(hit_valid && hit_stall && valid_s1) |-> scan_stall)
		else $error("held byte not stalled behind blocked result");

	// stored flag agrees with index and limit
	a_stored_flag: assert property (@(posedge clk) disable iff (!arst_n)
		hit_valid |-> (hit_item.stored == (hit_item.match_index < 32'(cfg_q.match_limit))))
		else $error("stored flag inconsistent with match index");

	// a new result appears only from a byte consumed in the previous cycle
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(hit_valid) |-> $past(go))
		else $error("result without a consumed byte");
`endif

endmodule

// File: sim/memory_pattern_scanner_checker.sv
// match predictor and result comparison for the memory pattern scanner
`timescale 1ns / 100ps

module memory_pattern_scanner_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                scan_valid,
	input  logic                scan_stall,
	input  msp_pkg::scan_item_t scan_item,
	input  logic                hit_valid,
	input  logic                hit_stall,
	input  msp_pkg::hit_item_t  hit_item,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [63:0]         cfg_data,
	output int                  mismatch_count,
	output int                  pending_hits
);
	import msp_pkg::*;

	localparam int HOLD_DEPTH = 16;

	// register copies
	logic [63:0] pat_low;
	logic [63:0] pat_high;
	logic [4:0]  pat_len;
	logic [15:0] loc_limit;

	// scan state
	logic [7:0]  held_bytes [HOLD_DEPTH];
	logic        held_writable [HOLD_DEPTH];
	int          held_count;
	logic [31:0] expected_address;
	logic [31:0] scan_matches;

	hit_item_t   predicted_hits [$];

	function automatic int compare_span();
		int n;
		n = pat_len;
		if (n == 0) begin
			n = 1;
		end
		if (n > HOLD_DEPTH) begin
			n = HOLD_DEPTH;
		end
		return n;
	endfunction

	task automatic drop_window();
		for (int i = 0; i < HOLD_DEPTH; i++) begin
			held_bytes[i] = 8'h00;
			held_writable[i] = 1'b0;
		end
		held_count = 0;
	endtask

	// take one byte into the window and queue the match it completes, if any
	task automatic advance_window(input scan_item_t req);
		int n;
		int first;
		logic found;
		logic [127:0] pat_bits;
		hit_item_t hit;
		if (req.restart) begin
			drop_window();
			scan_matches = '0;
		end else if (held_count != 0 && req.byte_address != expected_address) begin
			drop_window();
		end
		expected_address = req.byte_address + 32'd1;
		for (int i = 0; i < HOLD_DEPTH - 1; i++) begin
			held_bytes[i] = held_bytes[i + 1];
			held_writable[i] = held_writable[i + 1];
		end
		held_bytes[HOLD_DEPTH - 1] = req.data_byte;
		held_writable[HOLD_DEPTH - 1] = req.byte_writable;
		if (held_count < HOLD_DEPTH) begin
			held_count++;
		end
		n = compare_span();
		if (held_count >= n) begin
			first = HOLD_DEPTH - n;
			pat_bits = {pat_high, pat_low};
			found = 1'b1;
			for (int i = 0; i < n; i++) begin
				if (held_bytes[first + i] != pat_bits[8 * i +: 8]) begin
					found = 1'b0;
				end
			end
			if (found) begin
				hit.match_address = req.byte_address - 32'(n - 1);
				hit.match_mode = held_writable[first] ? MEM_RW : MEM_RO;
				hit.match_index = scan_matches;
				hit.stored = (scan_matches < {16'd0, loc_limit});
				predicted_hits.push_back(hit);
				if (scan_matches != '1) begin
					scan_matches++;
				end
				drop_window();
			end
		end
	endtask

	task automatic check_hit(input hit_item_t got);
		hit_item_t want;
		if (predicted_hits.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= 10) begin
				$display("unexpected hit: addr %h mode %b index %0d stored %b",
					got.match_address, got.match_mode, got.match_index, got.stored);
			end
		end else begin
			want = predicted_hits.pop_front();
			if (got.match_address !== want.match_address || got.match_mode !== want.match_mode
					|| got.match_index !== want.match_index || got.stored !== want.stored) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("hit mismatch: expected addr %h mode %b index %0d stored %b",
						want.match_address, want.match_mode, want.match_index, want.stored);
					$display("              got      addr %h mode %b index %0d stored %b",
						got.match_address, got.match_mode, got.match_index, got.stored);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low = '0;
			pat_high = '0;
			pat_len = 5'd1;
			loc_limit = 16'd20;
			drop_window();
			expected_address = '0;
			scan_matches = '0;
			predicted_hits.delete();
			mismatch_count = 0;
			pending_hits = 0;
		end else begin
			if (hit_valid && !hit_stall) begin
				check_hit(hit_item);
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					CFG_PATTERN_LOW:    pat_low = cfg_data;
					CFG_PATTERN_HIGH:   pat_high = cfg_data;
					CFG_PATTERN_LENGTH: pat_len = cfg_data[4:0];
					CFG_MATCH_LIMIT:    loc_limit = cfg_data[15:0];
				endcase
			end
			if (scan_valid && !scan_stall) begin
				advance_window(scan_item);
			end
			pending_hits = predicted_hits.size();
		end
	end

endmodule

// File: sim/memory_pattern_scanner_tb.sv
// testbench top: stimulus, receiver stalls and verdict for the memory pattern scanner
`timescale 1ns / 100ps

module memory_pattern_scanner_tb;
	import msp_pkg::*;

	// generous bound, the slowest legal run stays far below it
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        scan_valid;
	logic        scan_stall;
	scan_item_t  scan_item;
	logic        hit_valid;
	logic        hit_stall;
	hit_item_t   hit_item;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;
	int          mismatch_count;
	int          pending_hits;
	int          cycle_count = 0;

	// set by the stimulus, taken and timed by the receiver
	logic        hold_request = 1'b0;

	// bytes waiting to be sent, plus what the stimulus knows of the pattern
	scan_item_t  byte_plan [$];
	logic [127:0] pattern_bits = '0;
	int          pattern_span = 1;
	logic [31:0] scan_addr = '0;

	memory_pattern_scanner uut (.*);

	memory_pattern_scanner_checker checker_i (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// receiver: stall mode picked anew after each random span, long hold on demand
	initial begin
		stall_mode_t mode;
		int span;
		int hold_left;
		int tick;
		hit_stall <= 1'b0;
		hold_left = 0;
		tick = 0;
		forever begin
			mode = stall_mode_t'($urandom_range(0, 3));
			span = $urandom_range(16, 128);
			repeat (span) begin
				@(posedge clk);
				tick++;
				if (hold_request) begin
					hold_request = 1'b0;
					hold_left = HOLD_CYCLES;
				end
				if (hold_left > 0) begin
					hold_left--;
					hit_stall <= 1'b1;
				end else begin
					case (mode)
						STALL_NONE:     hit_stall <= 1'b0;
						STALL_LIGHT:    hit_stall <= ($urandom_range(0, 4) == 0);
						STALL_HEAVY:    hit_stall <= ($urandom_range(0, 3) != 0);
						STALL_PERIODIC: hit_stall <= (tick % 3 != 0);
					endcase
				end
			end
		end
	end

	task automatic put_byte(input logic [7:0] b, input logic [31:0] a, input logic w,
			input logic r);
		scan_item_t it;
		it.data_byte = b;
		it.byte_address = a;
		it.byte_writable = w;
		it.restart = r;
		byte_plan.push_back(it);
	endtask

	// hold the request until it is taken
	task automatic offer(input scan_item_t it);
		scan_valid <= 1'b1;
		scan_item <= it;
		do @(posedge clk); while (scan_stall);
	endtask

	// send the plan in bursts, valid drops between bursts
	task automatic run_plan();
		int burst;
		int gap;
		while (byte_plan.size() != 0) begin
			// now and then a long stretch with no gaps at all
			burst = ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(1, 24);
			while (burst > 0 && byte_plan.size() != 0) begin
				offer(byte_plan.pop_front());
				burst--;
			end
			scan_valid <= 1'b0;
			gap = $urandom_range(1, 9);
			repeat (gap) @(posedge clk);
		end
	endtask

	// sender pauses until every predicted match came back, then lets the pipe drain
	task automatic settle();
		while (pending_hits != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_PATTERN_LOW:  pattern_bits[63:0] = val;
			CFG_PATTERN_HIGH: pattern_bits[127:64] = val;
			CFG_PATTERN_LENGTH: begin
				pattern_span = val[4:0];
				if (pattern_span == 0) begin
					pattern_span = 1;
				end
				if (pattern_span > 16) begin
					pattern_span = 16;
				end
			end
			default: ;
		endcase
	endtask

	// only called with the block idle
	task automatic setup_regs(input logic [63:0] low, input logic [63:0] high,
			input logic [4:0] len, input logic [15:0] limit);
		write_reg(CFG_PATTERN_LOW, low);
		write_reg(CFG_PATTERN_HIGH, high);
		write_reg(CFG_PATTERN_LENGTH, {59'd0, len});
		write_reg(CFG_MATCH_LIMIT, {48'd0, limit});
		cfg_valid <= 1'b0;
	endtask

	// one setting, then mostly full pattern runs with random content around them
	task automatic random_phase(input int n_items);
		int sel;
		int kind;
		int corrupt_at;
		int break_at;
		int k;
		logic [4:0] len;
		logic [15:0] limit;
		logic [127:0] bits;
		logic [7:0] b;
		sel = $urandom_range(0, 9);
		case (sel)
			0, 1, 2, 3, 4: len = 5'($urandom_range(1, 4));
			5, 6:          len = 5'($urandom_range(5, 16));
			7:             len = 5'd16;
			8:             len = 5'd0;
			default:       len = 5'($urandom_range(17, 31));
		endcase
		kind = $urandom_range(0, 4);
		for (int i = 0; i < 16; i++) begin
			case (kind)
				0:       bits[8 * i +: 8] = 8'h00;
				1:       bits[8 * i +: 8] = 8'hFF;
				// two-letter alphabet makes partial and self-overlapping runs likely
				2:       bits[8 * i +: 8] = $urandom_range(0, 1) ? 8'h41 : 8'h42;
				default: bits[8 * i +: 8] = 8'($urandom_range(0, 255));
			endcase
		end
		case ($urandom_range(0, 4))
			0:       limit = 16'd0;
			1:       limit = 16'hFFFF;
			2:       limit = 16'($urandom_range(1, 6));
			3:       limit = 16'($urandom_range(0, 65535));
			default: limit = 16'd20;
		endcase
		setup_regs(bits[63:0], bits[127:64], len, limit);
		scan_addr = $urandom();
		while (byte_plan.size() < n_items) begin
			sel = $urandom_range(0, 9);
			if (sel <= 5) begin
				// full pattern run, sometimes with a wrong byte or a hole in the addresses
				corrupt_at = ($urandom_range(0, 6) == 0) ? $urandom_range(0, pattern_span - 1) : -1;
				break_at = ($urandom_range(0, 9) == 0 && pattern_span > 1) ?
					$urandom_range(1, pattern_span - 1) : -1;
				for (int i = 0; i < pattern_span; i++) begin
					b = pattern_bits[8 * i +: 8];
					if (i == corrupt_at) begin
						b = b ^ 8'($urandom_range(1, 255));
					end
					if (i == break_at) begin
						scan_addr = scan_addr + 32'($urandom_range(2, 9));
					end
					put_byte(b, scan_addr, 1'($urandom_range(0, 1)),
						(i == 0) && ($urandom_range(0, 19) == 0));
					scan_addr++;
				end
			end else if (sel <= 8) begin
				// noise, half of it made of pattern bytes
				k = $urandom_range(1, 5);
				repeat (k) begin
					b = $urandom_range(0, 1) ? pattern_bits[8 * $urandom_range(0, 15) +: 8] :
						8'($urandom_range(0, 255));
					put_byte(b, scan_addr, 1'($urandom_range(0, 1)), 1'b0);
					scan_addr++;
				end
			end else begin
				// jump, often to just below the top of the address space so runs wrap
				scan_addr = $urandom_range(0, 1) ? 32'hFFFF_FFFF - 32'($urandom_range(0, 20)) :
					$urandom();
				put_byte(8'($urandom_range(0, 255)), scan_addr, 1'($urandom_range(0, 1)),
					$urandom_range(0, 3) == 0);
				scan_addr++;
			end
		end
		run_plan();
		settle();
	endtask

	initial begin
		arst_n = 1'b0;
		scan_valid <= 1'b0;
		scan_item <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting: one zero byte is the pattern, match at the top address
		put_byte(8'h00, 32'hFFFF_FFFF, 1'b1, 1'b1);
		put_byte(8'hFF, 32'h0000_0000, 1'b0, 1'b0);
		run_plan();
		settle();

		// three-byte pattern, limit of one location
		setup_regs(64'h0000_0000_0080_00FF, 64'hFFFF_FFFF_FFFF_FFFF, 5'd3, 16'd1);
		// match across the address wrap, restart on its first byte
		put_byte(8'hFF, 32'hFFFF_FFFE, 1'b1, 1'b1);
		put_byte(8'h00, 32'hFFFF_FFFF, 1'b0, 1'b0);
		put_byte(8'h80, 32'h0000_0000, 1'b0, 1'b0);
		// hole in the addresses kills the partial match
		put_byte(8'hFF, 32'h0000_0010, 1'b1, 1'b0);
		put_byte(8'h00, 32'h0000_0012, 1'b1, 1'b0);
		put_byte(8'h80, 32'h0000_0013, 1'b1, 1'b0);
		// second match, index now at the limit and first byte read-only
		put_byte(8'hFF, 32'h0000_0020, 1'b0, 1'b0);
		put_byte(8'h00, 32'h0000_0021, 1'b1, 1'b0);
		put_byte(8'h80, 32'h0000_0022, 1'b1, 1'b0);
		run_plan();
		settle();

		// length zero behaves as one, nothing can be stored with limit zero
		setup_regs(64'h0000_0000_0000_00FF, 64'h0, 5'd0, 16'd0);
		put_byte(8'hFF, 32'h0000_0100, 1'b1, 1'b0);
		put_byte(8'hFF, 32'h0000_0101, 1'b0, 1'b0);
		run_plan();
		settle();

		// length above the window behaves as the full sixteen bytes
		setup_regs(64'h8877_6655_4433_2211, 64'hFF00_EEDD_CCBB_AA99, 5'd31, 16'hFFFF);
		for (int i = 0; i < 16; i++) begin
			put_byte(pattern_bits[8 * i +: 8], 32'hFFFF_FFF8 + 32'(i), 1'($urandom_range(0, 1)),
				i == 0);
		end
		run_plan();
		settle();

		// backpressure: receiver holds off while every byte is a match
		setup_regs(64'h0000_0000_0000_005A, 64'h0, 5'd1, 16'hFFFF);
		hold_request = 1'b1;
		for (int i = 0; i < 30; i++) begin
			put_byte(8'h5A, 32'h0000_1000 + 32'(i), 1'($urandom_range(0, 1)), 1'b0);
		end
		run_plan();
		settle();

		// random settings; count saturation needs 2^32 matches and is out of reach
		for (int p = 0; p < 8; p++) begin
			random_phase(120);
		end

		settle();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
